// ===== hw/rtl/gdr_pkg.sv =====
// Shared types and constants of the grid DDA raycaster.
`default_nettype none
package gdr_pkg;

  // command codes on the input port
  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_CAST  = 3'd1;
  localparam logic [2:0] CMD_FWD   = 3'd2;
  localparam logic [2:0] CMD_BACK  = 3'd3;
  localparam logic [2:0] CMD_ROTR  = 3'd4;
  localparam logic [2:0] CMD_ROTL  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_MOVE_STEP = 2'd0;
  localparam logic [1:0] CFG_ROT_COS   = 2'd1;
  localparam logic [1:0] CFG_ROT_SIN   = 2'd2;

  localparam int DIV_W = 40;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_CAST,
    OP_MOVE,
    OP_ROT
  } op_e;

  // classified command; neg = move back / turn right
  typedef struct packed {
    op_e         op;
    logic        neg;
    logic [4:0]  cx;
    logic [4:0]  cy;
    logic [2:0]  val;
    logic [10:0] col;
  } item_t;

  typedef struct packed {
    logic        ready;
    logic        clearing;
  } back_stat_t;

  typedef struct packed {
    logic [10:0]        move_step;
    logic signed [15:0] rot_cos;
    logic signed [15:0] rot_sin;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/grid_dda_raycaster.sv =====
// Top level of the grid DDA raycaster: config registers, front end, back end.
//
// Usage
//   Commands enter on start while busy is low; one transfer per such edge.
//   cmd_i selects: write a map cell, cast a screen column, move forward/back,
//   or rotate right/left. Only a cast produces a result.
//   Results appear on the result ports for exactly one cycle, marked by
//   result_valid_o; the receiver must take them then (it cannot stall).
//   Config registers (move_step, rot_cos, rot_sin) are written through
//   cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
// Queueing and sequencing
//   A two-entry queue sits between the front end and the sequencer, so two
//   commands can be taken while one is at work.
//   Cast: the camera coordinate, then the two bit-serial reciprocals, then
//   one map read per grid step (at most MAX_STEPS steps), then the height
//   divide when a wall is hit.
// Reset
//   After reset the map is cleared one cell per cycle (all 2^(2*ceil(log2
//   MAP_SIZE)) cells, 1024 for a 32x32 map); busy stays high meanwhile.
`default_nettype none
module grid_dda_raycaster
  import gdr_pkg::*;
#(
  parameter int MAP_SIZE      = 32,
  parameter int SCREEN_WIDTH  = 1280,
  parameter int SCREEN_HEIGHT = 960,
  parameter int MAX_STEPS     = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [4:0]  cell_x_i,
  input  wire logic [4:0]  cell_y_i,
  input  wire logic [2:0]  cell_value_i,
  input  wire logic [10:0] column_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             result_valid_o,
  output logic [10:0]      out_column_o,
  output logic [9:0]       draw_start_o,
  output logic [9:0]       draw_end_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic             wall_side_o,
  output logic [2:0]       wall_code_o,
  output logic             hit_found_o
);
  cfg_t       cfg_q;
  back_stat_t stat;
  logic       q_valid;
  item_t      q_item;

  // config registers; an unknown index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.move_step <= 11'd102;
      cfg_q.rot_cos   <= 16'sd16364;
      cfg_q.rot_sin   <= 16'sd819;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MOVE_STEP: cfg_q.move_step <= cfg_data_i[10:0];
        CFG_ROT_COS:   cfg_q.rot_cos   <= $signed(cfg_data_i);
        CFG_ROT_SIN:   cfg_q.rot_sin   <= $signed(cfg_data_i);
        default:       ;
      endcase
    end
  end

  // front end: handshake, classification, queue
  gdr_front #(.MAP_SIZE(MAP_SIZE)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .cmd_i        (cmd_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_value_i (cell_value_i),
    .column_i     (column_i),
    .stat_i       (stat),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item)
  );

  // back end: map, pose and the DDA sequencer
  gdr_back #(
    .MAP_SIZE      (MAP_SIZE),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAX_STEPS     (MAX_STEPS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .out_column_o   (out_column_o),
    .draw_start_o   (draw_start_o),
    .draw_end_o     (draw_end_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .wall_side_o    (wall_side_o),
    .wall_code_o    (wall_code_o),
    .hit_found_o    (hit_found_o)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/gdr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gdr_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/gdr_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module gdr_div
  import gdr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DIV_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DIV_W-1:0] quo_o
);
  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d, dsor_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DIV_W:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = CW'(DIV_W);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, dsor_q}) begin
        rem_d = trial - {1'b0, dsor_q};
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dsor_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

// ===== hw/rtl/gdr_front.sv =====
// Front end: takes commands, classifies them and queues them for the back end.
`default_nettype none
module gdr_front
  import gdr_pkg::*;
#(
  parameter int MAP_SIZE = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [4:0]  cell_x_i,
  input  wire logic [4:0]  cell_y_i,
  input  wire logic [2:0]  cell_value_i,
  input  wire logic [10:0] column_i,
  input  wire back_stat_t  stat_i,
  output logic             q_valid_o,
  output item_t            q_item_o
);
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  item_t      slot_q [2];
  item_t      item;
  logic       keep, push, pop;

  always_comb begin
    item.op  = OP_CAST;
    item.neg = 1'b0;
    item.cx  = cell_x_i;
    item.cy  = cell_y_i;
    item.val = cell_value_i;
    item.col = column_i;
    keep     = 1'b1;
    case (cmd_i)
      CMD_WRITE: begin
        item.op = OP_WRITE;
        keep    = (32'(cell_x_i) < MAP_SIZE) && (32'(cell_y_i) < MAP_SIZE);
      end
      CMD_CAST: item.op = OP_CAST;
      CMD_FWD, CMD_BACK: begin
        item.op  = OP_MOVE;
        item.neg = (cmd_i == CMD_BACK);
      end
      CMD_ROTR, CMD_ROTL: begin
        item.op  = OP_ROT;
        item.neg = (cmd_i == CMD_ROTR);
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy_o    = (cnt_q == 2'd2) || stat_i.clearing;
  assign push      = start_i && !busy_o && keep;
  assign pop       = stat_i.ready && (cnt_q != 2'd0);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = slot_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    if (!push && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wp_q] <= item;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/gdr_back.sv =====
// Back end: pose, map and the cast / move / rotate sequencer.
`default_nettype none
module gdr_back
  import gdr_pkg::*;
#(
  parameter int MAP_SIZE      = 32,
  parameter int SCREEN_WIDTH  = 1280,
  parameter int SCREEN_HEIGHT = 960,
  parameter int MAX_STEPS     = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        q_valid_i,
  input  wire item_t       q_item_i,
  output back_stat_t       stat_o,
  output logic             result_valid_o,
  output logic [10:0]      out_column_o,
  output logic [9:0]       draw_start_o,
  output logic [9:0]       draw_end_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic             wall_side_o,
  output logic [2:0]       wall_code_o,
  output logic             hit_found_o
);
  localparam int MW    = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
  localparam int AW    = 2 * MW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = $clog2(MAX_STEPS + 1);
  localparam logic signed [7:0] MSZ = 8'(MAP_SIZE);
  localparam logic [DIV_W-1:0] LINE_MAX = DIV_W'(2 * SCREEN_HEIGHT);
  localparam logic signed [15:0] HALF_H = 16'(SCREEN_HEIGHT / 2);
  localparam logic signed [15:0] LAST_ROW = 16'(SCREEN_HEIGHT - 1);
  // reciprocal of the screen width for the camera coordinate; the estimate
  // is at most one low and gets one compare-and-correct step
  localparam logic [23:0] CAM_RCP = 24'((1 << 27) / SCREEN_WIDTH);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_CAM   = 5'd2;
  localparam logic [4:0] S_CAMW  = 5'd3;
  localparam logic [4:0] S_RX    = 5'd4;
  localparam logic [4:0] S_RY    = 5'd5;
  localparam logic [4:0] S_RYD   = 5'd6;
  localparam logic [4:0] S_DX    = 5'd7;
  localparam logic [4:0] S_DXW   = 5'd8;
  localparam logic [4:0] S_DY    = 5'd9;
  localparam logic [4:0] S_DYW   = 5'd10;
  localparam logic [4:0] S_SX    = 5'd11;
  localparam logic [4:0] S_SY    = 5'd12;
  localparam logic [4:0] S_SYD   = 5'd13;
  localparam logic [4:0] S_STEP  = 5'd14;
  localparam logic [4:0] S_CHK   = 5'd15;
  localparam logic [4:0] S_PERP  = 5'd16;
  localparam logic [4:0] S_PERPW = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;
  localparam logic [4:0] S_M0    = 5'd19;
  localparam logic [4:0] S_M1    = 5'd20;
  localparam logic [4:0] S_M2    = 5'd21;
  localparam logic [4:0] S_MXA   = 5'd22;
  localparam logic [4:0] S_MXC   = 5'd23;
  localparam logic [4:0] S_MYA   = 5'd24;
  localparam logic [4:0] S_MYC   = 5'd25;
  localparam logic [4:0] S_R0    = 5'd26;
  localparam logic [4:0] S_R1    = 5'd27;
  localparam logic [4:0] S_R2    = 5'd28;
  localparam logic [4:0] S_R3    = 5'd29;
  localparam logic [4:0] S_R4    = 5'd30;

  function automatic logic [AW-1:0] cell_addr(input logic [7:0] cx, input logic [7:0] cy);
    cell_addr = {cx[MW-1:0], cy[MW-1:0]};
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [36:0] v);
    if (v > 37'sd32767)       sat16 = 16'sh7fff;
    else if (v < -37'sd32768) sat16 = 16'sh8000;
    else                      sat16 = v[15:0];
  endfunction

  logic [4:0] state_q, state_d;
  item_t      item_q;
  logic [15:0] pos_x_q, pos_y_q;
  logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic signed [15:0] cam_q, tmp_q, dx_q, dy_q;
  logic [15:0] camq_q;
  logic signed [18:0] rx_q, ry_q;
  logic [31:0] ddx_q, ddy_q;
  logic [DIV_W-1:0] sdx_q, sdy_q;
  logic signed [7:0] mx_q, my_q;
  logic        side_q, hit_q, ok_q, pair_q;
  logic [2:0]  code_q;
  logic [NW-1:0] n_q;
  logic [13:0] line_q;
  logic [15:0] npos_q;
  logic [AW-1:0] clr_q;
  logic signed [50:0] prod_q, acc_q;

  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [17:0] rc, rs;
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_dend, div_dsor, div_quo;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [2:0]        ram_wdata, ram_rdata;
  logic              take;

  // combinational helpers
  logic [10:0] col_c;
  logic [27:0] cam_prod, cam_rem;
  logic [15:0] cam_fix;
  logic [11:0] fracx, fracy;
  logic [18:0] abs_rx, abs_ry;
  logic signed [7:0] nmx, nmy;
  logic [DIV_W-1:0] nsdx, nsdy, perp;
  logic        nside, in_map;
  logic signed [15:0] mdelta;
  logic signed [17:0] px, py;
  logic        px_ok, py_ok;
  logic signed [50:0] rsum;
  logic signed [15:0] ds, de, lh2;
  logic [7:0]  full;

  gdr_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gdr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dend),
    .divisor_i  (div_dsor),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  assign take           = (state_q == S_IDLE) && q_valid_i;
  assign stat_o.ready    = (state_q == S_IDLE);
  assign stat_o.clearing = (state_q == S_CLR);

  assign ram_we    = (state_q == S_CLR) || (take && q_item_i.op == OP_WRITE);
  assign ram_waddr = (state_q == S_CLR) ? clr_q
                   : cell_addr({3'b0, q_item_i.cx}, {3'b0, q_item_i.cy});
  assign ram_wdata = (state_q == S_CLR) ? 3'd0 : q_item_i.val;

  assign col_c  = (32'(item_q.col) < SCREEN_WIDTH) ? item_q.col : 11'(SCREEN_WIDTH - 1);
  // camera coordinate: col * 2^15 / width by reciprocal, then one correction
  assign cam_prod = 28'(col_c) * 28'(CAM_RCP);
  assign cam_rem  = {2'b0, col_c, 15'b0} - 28'(camq_q) * 28'(SCREEN_WIDTH);
  assign cam_fix  = (cam_rem >= 28'(SCREEN_WIDTH)) ? camq_q + 16'd1 : camq_q;
  assign abs_rx = rx_q[18] ? 19'(-rx_q) : rx_q;
  assign abs_ry = ry_q[18] ? 19'(-ry_q) : ry_q;
  assign fracx  = rx_q[18] ? {1'b0, pos_x_q[10:0]} : 12'd2048 - {1'b0, pos_x_q[10:0]};
  assign fracy  = ry_q[18] ? {1'b0, pos_y_q[10:0]} : 12'd2048 - {1'b0, pos_y_q[10:0]};
  assign rc     = 18'(cfg_i.rot_cos);
  assign rs     = item_q.neg ? -18'(cfg_i.rot_sin) : 18'(cfg_i.rot_sin);
  assign perp   = side_q ? (sdy_q - DIV_W'(ddy_q)) : (sdx_q - DIV_W'(ddx_q));
  assign mdelta = item_q.neg ? -$signed(prod_q[29:14]) : $signed(prod_q[29:14]);
  assign px     = $signed({2'b0, pos_x_q}) + 18'(dx_q);
  assign py     = $signed({2'b0, pos_y_q}) + 18'(dy_q);
  assign px_ok  = (px[17:16] == 2'b00) && (32'(px[15:11]) < MAP_SIZE)
                  && (32'(pos_y_q[15:11]) < MAP_SIZE);
  assign py_ok  = (py[17:16] == 2'b00) && (32'(py[15:11]) < MAP_SIZE)
                  && (32'(pos_x_q[15:11]) < MAP_SIZE);
  assign rsum   = (state_q == S_R2) ? (acc_q - prod_q) : (acc_q + prod_q);

  // one DDA step
  always_comb begin
    nmx   = mx_q;
    nmy   = my_q;
    nsdx  = sdx_q;
    nsdy  = sdy_q;
    nside = 1'b1;
    if (sdx_q < sdy_q) begin
      nsdx  = sdx_q + DIV_W'(ddx_q);
      nmx   = rx_q[18] ? mx_q - 8'sd1 : mx_q + 8'sd1;
      nside = 1'b0;
    end else begin
      nsdy = sdy_q + DIV_W'(ddy_q);
      nmy  = ry_q[18] ? my_q - 8'sd1 : my_q + 8'sd1;
    end
    in_map = (nmx >= 8'sd0) && (nmx < MSZ) && (nmy >= 8'sd0) && (nmy < MSZ);
  end

  always_comb begin
    case (state_q)
      S_STEP:  ram_raddr = cell_addr(nmx, nmy);
      S_MXA:   ram_raddr = cell_addr({3'b0, px[15:11]}, {3'b0, pos_y_q[15:11]});
      S_MYA:   ram_raddr = cell_addr({3'b0, pos_x_q[15:11]}, {3'b0, py[15:11]});
      default: ram_raddr = '0;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_RX:  begin mul_a = 33'(plane_x_q); mul_b = 18'(cam_q); end
      S_RY:  begin mul_a = 33'(plane_y_q); mul_b = 18'(cam_q); end
      S_SX:  begin mul_a = $signed({1'b0, ddx_q}); mul_b = $signed({6'b0, fracx}); end
      S_SY:  begin mul_a = $signed({1'b0, ddy_q}); mul_b = $signed({6'b0, fracy}); end
      S_M0:  begin mul_a = 33'(dir_x_q); mul_b = $signed({7'b0, cfg_i.move_step}); end
      S_M1:  begin mul_a = 33'(dir_y_q); mul_b = $signed({7'b0, cfg_i.move_step}); end
      S_R0:  begin mul_a = pair_q ? 33'(plane_x_q) : 33'(dir_x_q); mul_b = rc; end
      S_R1:  begin mul_a = pair_q ? 33'(plane_y_q) : 33'(dir_y_q); mul_b = rs; end
      S_R2:  begin mul_a = pair_q ? 33'(plane_x_q) : 33'(dir_x_q); mul_b = rs; end
      S_R3:  begin mul_a = pair_q ? 33'(plane_y_q) : 33'(dir_y_q); mul_b = rc; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_dend  = '0;
    div_dsor  = '0;
    case (state_q)
      S_DX: begin
        div_start = (rx_q != '0);
        div_dend  = DIV_W'(1) << 30;
        div_dsor  = DIV_W'(abs_rx);
      end
      S_DY: begin
        div_start = (ry_q != '0);
        div_dend  = DIV_W'(1) << 30;
        div_dsor  = DIV_W'(abs_ry);
      end
      S_PERP: begin
        div_start = (perp != '0);
        div_dend  = DIV_W'(SCREEN_HEIGHT) << 16;
        div_dsor  = perp;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:   if (&clr_q) state_d = S_IDLE;
      S_IDLE: begin
        if (take) begin
          case (q_item_i.op)
            OP_CAST: state_d = S_CAM;
            OP_MOVE: state_d = S_M0;
            OP_ROT:  state_d = S_R0;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CAM:   state_d = S_CAMW;
      S_CAMW:  state_d = S_RX;
      S_RX:    state_d = S_RY;
      S_RY:    state_d = S_RYD;
      S_RYD:   state_d = S_DX;
      S_DX:    state_d = (rx_q == '0) ? S_DY : S_DXW;
      S_DXW:   if (div_done) state_d = S_DY;
      S_DY:    state_d = (ry_q == '0) ? S_SX : S_DYW;
      S_DYW:   if (div_done) state_d = S_SX;
      S_SX:    state_d = S_SY;
      S_SY:    state_d = S_SYD;
      S_SYD:   state_d = S_STEP;
      S_STEP:  state_d = in_map ? S_CHK : S_OUT;
      S_CHK: begin
        if (ram_rdata != 3'd0)            state_d = S_PERP;
        else if (32'(n_q) >= MAX_STEPS)   state_d = S_OUT;
        else                              state_d = S_STEP;
      end
      S_PERP:  state_d = (perp == '0) ? S_OUT : S_PERPW;
      S_PERPW: if (div_done) state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      S_M0:    state_d = S_M1;
      S_M1:    state_d = S_M2;
      S_M2:    state_d = S_MXA;
      S_MXA:   state_d = S_MXC;
      S_MXC:   state_d = S_MYA;
      S_MYA:   state_d = S_MYC;
      S_MYC:   state_d = S_IDLE;
      S_R0:    state_d = S_R1;
      S_R1:    state_d = S_R2;
      S_R2:    state_d = S_R3;
      S_R3:    state_d = S_R4;
      S_R4:    state_d = pair_q ? S_IDLE : S_R0;
      default: state_d = S_IDLE;
    endcase
  end

  // stripe and color of the final result
  always_comb begin
    lh2  = 16'(line_q >> 1);
    ds   = HALF_H - lh2;
    de   = lh2 + HALF_H;
    if (ds < 16'sd0)   ds = 16'sd0;
    if (de > LAST_ROW) de = LAST_ROW;
    full = side_q ? 8'd127 : 8'd255;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLR;
      clr_q          <= '0;
      result_valid_o <= 1'b0;
      pos_x_q        <= 16'd10240;
      pos_y_q        <= 16'd10240;
      dir_x_q        <= -16'sd16384;
      dir_y_q        <= 16'sd0;
      plane_x_q      <= 16'sd0;
      plane_y_q      <= 16'sd10813;
      pair_q         <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= (state_q == S_OUT);
      if (state_q == S_CLR) clr_q <= clr_q + AW'(1);
      if (state_q == S_MXC && ok_q && ram_rdata == 3'd0) pos_x_q <= npos_q;
      if (state_q == S_MYC && ok_q && ram_rdata == 3'd0) pos_y_q <= npos_q;
      if (state_q == S_IDLE) pair_q <= 1'b0;
      if (state_q == S_R4) begin
        pair_q <= 1'b1;
        if (pair_q) begin
          plane_x_q <= tmp_q;
          plane_y_q <= sat16(rsum[50:14]);
        end else begin
          dir_x_q <= tmp_q;
          dir_y_q <= sat16(rsum[50:14]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (take) item_q <= q_item_i;
    case (state_q)
      S_CAM:   camq_q <= cam_prod[27:12];
      S_CAMW:  cam_q <= $signed(cam_fix) - 16'sd16384;
      S_RY:    rx_q  <= 19'(dir_x_q) + $signed(prod_q[32:14]);
      S_RYD:   ry_q  <= 19'(dir_y_q) + $signed(prod_q[32:14]);
      S_DX:    ddx_q <= 32'hffff_ffff;
      S_DXW:   ddx_q <= div_quo[31:0];
      S_DY:    ddy_q <= 32'hffff_ffff;
      S_DYW:   ddy_q <= div_quo[31:0];
      S_SY:    sdx_q <= prod_q[50:11];
      S_SYD: begin
        sdy_q <= prod_q[50:11];
        mx_q  <= $signed({3'b0, pos_x_q[15:11]});
        my_q  <= $signed({3'b0, pos_y_q[15:11]});
        n_q   <= '0;
        hit_q <= 1'b0;
      end
      S_STEP: begin
        sdx_q  <= nsdx;
        sdy_q  <= nsdy;
        mx_q   <= nmx;
        my_q   <= nmy;
        side_q <= nside;
        n_q    <= n_q + NW'(1);
      end
      S_CHK: begin
        code_q <= ram_rdata;
        hit_q  <= (ram_rdata != 3'd0);
      end
      S_PERP:  line_q <= 14'(LINE_MAX);
      S_PERPW: line_q <= (div_quo < LINE_MAX) ? div_quo[13:0] : 14'(LINE_MAX);
      S_M1:    dx_q <= mdelta;
      S_M2:    dy_q <= mdelta;
      S_MXA: begin
        ok_q   <= px_ok;
        npos_q <= px[15:0];
      end
      S_MYA: begin
        ok_q   <= py_ok;
        npos_q <= py[15:0];
      end
      S_R1:    acc_q <= prod_q;
      S_R2:    tmp_q <= sat16(rsum[50:14]);
      S_R3:    acc_q <= prod_q;
      default: ;
    endcase
    if (state_q == S_OUT) begin
      out_column_o <= item_q.col;
      draw_start_o <= '0;
      draw_end_o   <= '0;
      red_o        <= '0;
      green_o      <= '0;
      blue_o       <= '0;
      wall_side_o  <= 1'b0;
      wall_code_o  <= '0;
      hit_found_o  <= 1'b0;
      if (hit_q) begin
        draw_start_o <= ds[9:0];
        draw_end_o   <= de[9:0];
        wall_side_o  <= side_q;
        wall_code_o  <= code_q;
        hit_found_o  <= 1'b1;
        case (code_q)
          3'd1:    red_o <= full;
          3'd2:    green_o <= full;
          3'd3:    blue_o <= full;
          3'd4: begin
            red_o   <= full;
            green_o <= full;
            blue_o  <= full;
          end
          default: begin
            red_o   <= full;
            green_o <= full;
          end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the grid DDA raycaster: predictor, stimulus and result checks.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gdr_pkg::*;

  // Opcodes 6 and 7 are not decoded. The block must ignore them.
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int MAP_N      = 32;
  localparam int SCR_W      = 1280;
  localparam int SCR_H      = 960;
  localparam int STEP_CAP   = 64;
  localparam int SETTLE     = 400;    // longer than any non-cast command plus the queue
  localparam int STALL_MAX  = 20000;  // idle cycles before the watchdog fires

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  cmd_i = '0;
  logic [4:0]  cell_x_i = '0, cell_y_i = '0;
  logic [2:0]  cell_value_i = '0;
  logic [10:0] column_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [10:0] out_column_o;
  logic [9:0]  draw_start_o, draw_end_o;
  logic [7:0]  red_o, green_o, blue_o;
  logic        wall_side_o, hit_found_o;
  logic [2:0]  wall_code_o;

  grid_dda_raycaster DUT (.*);

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [10:0] column;
    logic [9:0]  dstart;
    logic [9:0]  dend;
    logic [7:0]  r, g, b;
    logic        side;
    logic [2:0]  code;
    logic        hit;
  } stripe_t;

  // Model copy of the map, the player pose and the configuration registers.
  logic [2:0] grid_m [MAP_N*MAP_N];
  longint pos_x, pos_y, dir_x, dir_y, plane_x, plane_y;
  longint step_len, rc, rs;

  stripe_t stripe_q[$];      // stripes still to be received, oldest first
  int errors = 0, n_items = 0, n_stripes = 0, n_hits = 0, stall = 0, idle_pct = 0;

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic bit cell_open(longint px, longint py);
    if (px < 0 || px > 65535 || py < 0 || py > 65535) return 0;
    if ((px >> 11) >= MAP_N || (py >> 11) >= MAP_N) return 0;
    return grid_m[(px >> 11) * MAP_N + (py >> 11)] == 0;
  endfunction

  function automatic longint unsigned inv_dist(longint r);
    longint unsigned a;
    a = (r < 0) ? -r : r;
    return (a == 0) ? 64'hFFFF_FFFF : (64'd1 << 30) / a;
  endfunction

  // Walk the ray through the grid and work out the wall stripe for one column.
  function automatic stripe_t trace_column(logic [10:0] col);
    stripe_t s;
    longint c, cam, rx, ry, mx, my, stx, sty, ds, de;
    longint unsigned fx, fy, ddx, ddy, sdx, sdy, perp, lh;
    logic [7:0] full;
    int side;
    bit hit;
    s = '0;
    s.column = col;
    c = (col < SCR_W) ? longint'(col) : longint'(SCR_W - 1);
    cam = (2 * c * 16384) / SCR_W - 16384;
    rx = dir_x + ((plane_x * cam) >>> 14);
    ry = dir_y + ((plane_y * cam) >>> 14);
    mx = pos_x >> 11;
    my = pos_y >> 11;
    fx = pos_x & 2047;
    fy = pos_y & 2047;
    ddx = inv_dist(rx);
    ddy = inv_dist(ry);
    sdx = (((rx < 0) ? fx : 2048 - fx) * ddx) >> 11;
    sdy = (((ry < 0) ? fy : 2048 - fy) * ddy) >> 11;
    stx = (rx < 0) ? -1 : 1;
    sty = (ry < 0) ? -1 : 1;
    side = 0;
    hit = 0;
    for (int n = 0; n < STEP_CAP; n++) begin
      if (sdx < sdy) begin
        sdx += ddx; mx += stx; side = 0;
      end else begin
        sdy += ddy; my += sty; side = 1;
      end
      if (mx < 0 || mx >= MAP_N || my < 0 || my >= MAP_N) break;
      s.code = grid_m[mx * MAP_N + my];
      if (s.code != 0) begin
        hit = 1;
        break;
      end
    end
    if (!hit) begin
      s.code = '0;
      return s;
    end
    perp = side ? sdy - ddy : sdx - ddx;
    lh = 2 * SCR_H;
    if (perp != 0 && ((64'(SCR_H) << 16) / perp) < lh) lh = (64'(SCR_H) << 16) / perp;
    ds = SCR_H / 2 - longint'(lh) / 2;
    de = longint'(lh) / 2 + SCR_H / 2;
    s.dstart = 10'((ds < 0) ? 0 : ds);
    s.dend = 10'((de > SCR_H - 1) ? SCR_H - 1 : de);
    full = side ? 8'd127 : 8'd255;
    case (s.code)
      3'd1: s.r = full;
      3'd2: s.g = full;
      3'd3: s.b = full;
      3'd4: begin
        s.r = full; s.g = full; s.b = full;
      end
      default: begin
        s.r = full; s.g = full;
      end
    endcase
    s.side = 1'(side);
    s.hit = 1;
    return s;
  endfunction

  // Advance the model by one accepted command.
  task automatic apply_cmd(logic [2:0] cmd, logic [4:0] cx, logic [4:0] cy,
                           logic [2:0] val, logic [10:0] col);
    longint dx, dy, sg, sn, ox, oy;
    case (cmd)
      CMD_WRITE: grid_m[cx * MAP_N + cy] = val;
      CMD_CAST: begin
        stripe_q.push_back(trace_column(col));
        n_stripes++;
      end
      CMD_FWD, CMD_BACK: begin
        sg = (cmd == CMD_FWD) ? 1 : -1;
        dx = ((dir_x * step_len) >>> 14) * sg;
        dy = ((dir_y * step_len) >>> 14) * sg;
        if (cell_open(pos_x + dx, pos_y)) pos_x += dx;
        if (cell_open(pos_x, pos_y + dy)) pos_y += dy;
      end
      CMD_ROTR, CMD_ROTL: begin
        sn = (cmd == CMD_ROTL) ? rs : -rs;
        ox = dir_x; oy = dir_y;
        dir_x = sat16((ox * rc - oy * sn) >>> 14);
        dir_y = sat16((ox * sn + oy * rc) >>> 14);
        ox = plane_x; oy = plane_y;
        plane_x = sat16((ox * rc - oy * sn) >>> 14);
        plane_y = sat16((ox * sn + oy * rc) >>> 14);
      end
      default: ;
    endcase
  endtask

  // One command transfer. start stays high into the next call unless the sender idles.
  task automatic send_cmd(logic [2:0] cmd, logic [4:0] cx, logic [4:0] cy,
                          logic [2:0] val, logic [10:0] col);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= cmd;
    cell_x_i <= cx;
    cell_y_i <= cy;
    cell_value_i <= val;
    column_i <= col;
    do @(posedge clk_i); while (busy);
    apply_cmd(cmd, cx, cy, val, col);
    n_items++;
  endtask

  task automatic cast_col(logic [10:0] col);
    send_cmd(CMD_CAST, 5'($urandom), 5'($urandom), 3'($urandom), col);
  endtask

  task automatic write_cell(int x, int y, int v);
    send_cmd(CMD_WRITE, 5'(x), 5'(y), 3'(v), 11'($urandom));
  endtask

  // Drain outstanding work, then write the three registers back to back.
  task automatic set_regs(int step, int cs, int sn);
    start <= 1'b0;
    @(posedge clk_i);
    wait (stripe_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MOVE_STEP;
    cfg_data_i <= 16'(step);
    @(posedge clk_i);
    step_len = step;
    cfg_idx_i <= CFG_ROT_COS;
    cfg_data_i <= 16'(cs);
    @(posedge clk_i);
    rc = cs;
    cfg_idx_i <= CFG_ROT_SIN;
    cfg_data_i <= 16'(sn);
    @(posedge clk_i);
    rs = sn;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    // Empty map: every ray runs off the edge, no hit.
    cast_col(11'd0);
    cast_col(11'd1279);
    // Column past the screen edge is traced as the last column but echoed as given.
    cast_col(11'd2047);
    // Wall the map along its first row and first column and put a wall right next to the player.
    for (int i = 0; i < MAP_N; i++) write_cell(i, 0, 1 + i % 7);
    for (int i = 0; i < MAP_N; i++) write_cell(0, i, 2);
    write_cell(4, 5, 7);
    cast_col(11'd640);
    // Walking into the wall must be refused, backing off must not.
    send_cmd(CMD_FWD, '0, '0, '0, '0);
    send_cmd(CMD_BACK, '0, '0, '0, '0);
    send_cmd(CMD_ROTR, '0, '0, '0, '0);
    send_cmd(CMD_ROTL, '0, '0, '0, '0);
    send_cmd(CMD_SPARE6, 5'd31, 5'd31, 3'd7, 11'h7FF);
    send_cmd(CMD_SPARE7, '0, '0, '0, '0);
    write_cell(31, 31, 3);
    write_cell(4, 5, 0);
    cast_col(11'd320);
    cast_col(11'd1000);
  endtask

  task automatic test_random(int count);
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) cast_col(11'($urandom_range(2047)));
      else if (pick < 70)
        // mostly clear cells so the map stays walkable
        write_cell($urandom_range(31), $urandom_range(31),
                   ($urandom_range(2) == 0) ? $urandom_range(7, 1) : 0);
      else if (pick < 85)
        send_cmd(($urandom_range(1) == 0) ? CMD_FWD : CMD_BACK, 5'($urandom), 5'($urandom),
                 3'($urandom), 11'($urandom));
      else if (pick < 97)
        send_cmd(($urandom_range(1) == 0) ? CMD_ROTR : CMD_ROTL, '0, '0, '0, '0);
      else send_cmd(($urandom_range(1) == 0) ? CMD_SPARE6 : CMD_SPARE7, 5'($urandom),
                    5'($urandom), 3'($urandom), 11'($urandom));
    end
  endtask

  // Results cannot be stalled, so every strobe is checked at the edge that ends it.
  always @(posedge clk_i) begin
    stripe_t got, want;
    if ((start && !busy) || result_valid_o) stall <= 0;
    else stall <= stall + 1;
    if (rst_ni && result_valid_o) begin
      got = {out_column_o, draw_start_o, draw_end_o, red_o, green_o, blue_o,
             wall_side_o, wall_code_o, hit_found_o};
      if (stripe_q.size() == 0) begin
        errors++;
        $display("%t: unexpected stripe %p", $realtime, got);
      end else begin
        want = stripe_q.pop_front();
        if (want.hit) n_hits++;
        if (got.column !== want.column || got.dstart !== want.dstart ||
            got.dend !== want.dend || got.r !== want.r || got.g !== want.g ||
            got.b !== want.b || got.side !== want.side || got.code !== want.code ||
            got.hit !== want.hit) begin
          errors++;
          $display("%t: stripe mismatch expected %p actual %p", $realtime, want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall >= STALL_MAX) begin
      $display("%t: watchdog expired, %0d stripes outstanding", $realtime, stripe_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    foreach (grid_m[i]) grid_m[i] = '0;
    pos_x = 10240; pos_y = 10240;
    dir_x = -16384; dir_y = 0;
    plane_x = 0; plane_y = 10813;
    step_len = 102; rc = 16364; rs = 819;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_pct = 7;
    test_directed();
    test_random(100);
    set_regs(2047, 32767, -32768);
    test_random(50);
    set_regs(0, -32768, 32767);
    test_random(50);
    set_regs(300, 15700, 4600);
    idle_pct = 83;
    test_random(130);
    idle_pct = 0;
    test_random(140);
    start <= 1'b0;
    wait (stripe_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    $display("Covered %0d commands, %0d casts (%0d hitting a wall), four register settings.",
             n_items, n_stripes, n_hits);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
